// ----- hdl/mlfq_pkg.sv -----
// Shared types and constants for the multilevel feedback scheduler.
package mlfq_pkg;

    localparam int OpcodeW  = 1;
    localparam int SlotW    = 4;
    localparam int TimeW    = 32;
    localparam int BurstW   = 16;
    localparam int StatusW  = 2;
    localparam int LevelW   = 3;
    localparam int RunW     = 8;
    localparam int InDataW  = 56;   // 53 bits of fields, padded to bytes
    localparam int OutDataW = 120;  // 115 bits of fields, padded to bytes

    localparam logic [OpcodeW-1:0] OP_ADMIT    = 1'b0;
    localparam logic [OpcodeW-1:0] OP_DISPATCH = 1'b1;

    localparam logic [StatusW-1:0] ST_OK      = 2'd0;
    localparam logic [StatusW-1:0] ST_BUSY    = 2'd1;
    localparam logic [StatusW-1:0] ST_ZERO    = 2'd2;
    localparam logic [StatusW-1:0] ST_NOREADY = 2'd3;

    typedef struct packed {
        logic [OpcodeW-1:0] opcode;
        logic [SlotW-1:0]   slot;
        logic [TimeW-1:0]   arrival_time;
        logic [BurstW-1:0]  burst;
    } cmd_t;

    typedef struct packed {
        logic [StatusW-1:0] status;
        logic [SlotW-1:0]   chosen_slot;
        logic [LevelW-1:0]  chosen_level;
        logic [RunW-1:0]    run_length;
        logic               finished;
        logic               context_switch;
        logic [TimeW-1:0]   clock_now;
        logic [TimeW-1:0]   turnaround;
        logic [TimeW-1:0]   switch_total;
    } result_t;

endpackage

// ----- hdl/multilevel_feedback_scheduler.sv -----
// Top level of the multilevel feedback queue scheduler.
//
//  channel  | dir | tdata fields (low bit up)
//  s_axis   | in  | opcode, slot, arrival_time, burst (56 bits)
//  m_axis   | out | status, chosen_slot, chosen_level, run_length, finished,
//           |     | context_switch, clock_now, turnaround, switch_total (120 bits)
//
// In the back end, S_SELECT registers the priority search over the slot table,
// then S_EXEC executes the item and loads the result register.
// rst_n clears the ready bits, clock and switch count and sets last slot to none, at once.
// A two-beat queue decouples input from execution; a stalled output holds
// the result and blocks only the back end while the queue keeps filling.
module multilevel_feedback_scheduler
#(
    parameter int SLOTS  = 16,
    parameter int LEVELS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // opcode, slot, arrival_time, burst, pad
    input  logic [mlfq_pkg::InDataW-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status, chosen_slot, chosen_level, run_length, finished, context_switch,
    // clock_now, turnaround, switch_total, pad
    output logic [mlfq_pkg::OutDataW-1:0]   m_axis_tdata
);

    logic              cmd_valid;
    logic              cmd_ready;
    mlfq_pkg::cmd_t    cmd;
    mlfq_pkg::result_t res;

    mlfq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    mlfq_back #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    // Pack the result beat, first field in the low bits
    assign m_axis_tdata = {5'b00000, res.switch_total, res.turnaround, res.clock_now,
                           res.context_switch, res.finished, res.run_length,
                           res.chosen_level, res.chosen_slot, res.status};

endmodule

// ----- hdl/mlfq_front.sv -----
// Front end: accept input beats, unpack them and hold them in a two-entry queue.
module mlfq_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mlfq_pkg::InDataW-1:0]   s_tdata,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output mlfq_pkg::cmd_t                 cmd
);

    mlfq_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push, pop;
    mlfq_pkg::cmd_t in_cmd;

    always_comb
    begin
        in_cmd.opcode       = s_tdata[0];
        in_cmd.slot         = s_tdata[4:1];
        in_cmd.arrival_time = s_tdata[36:5];
        in_cmd.burst        = s_tdata[52:37];
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/mlfq_back.sv -----
// Back end: slot table, dispatch selection and result register.
module mlfq_back
#(
    parameter int SLOTS  = 16,
    parameter int LEVELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  mlfq_pkg::cmd_t        cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mlfq_pkg::result_t     res
);

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [0:0] {S_SELECT, S_EXEC} state_t;

    state_t                        state_reg;
    logic [SLOTS-1:0]              ready_reg;
    logic [mlfq_pkg::LevelW-1:0]   level_reg  [SLOTS];
    logic [mlfq_pkg::BurstW-1:0]   remain_reg [SLOTS];
    logic [mlfq_pkg::TimeW-1:0]    arrive_reg [SLOTS];
    logic [mlfq_pkg::TimeW-1:0]    clock_reg;
    logic [4:0]                    last_reg;
    logic [mlfq_pkg::TimeW-1:0]    switch_reg;
    logic                          found_reg;
    logic [IdxW-1:0]               best_reg;
    logic                          out_valid_reg;
    mlfq_pkg::result_t             out_reg;

    // Priority search: lowest level, then lowest slot (combinational, one item)
    logic                          found;
    logic [IdxW-1:0]               best;
    logic [mlfq_pkg::LevelW:0]     best_lvl;

    always_comb
    begin
        found    = 1'b0;
        best     = '0;
        best_lvl = {1'b1, {mlfq_pkg::LevelW{1'b0}}};
        for (int s = 0; s < SLOTS; s++)
        begin
            if (ready_reg[s] && ({1'b0, level_reg[s]} < best_lvl))
            begin
                found    = 1'b1;
                best     = IdxW'(s);
                best_lvl = {1'b0, level_reg[s]};
            end
        end
    end

    logic                         in_range;
    logic [IdxW-1:0]              adm_idx;
    logic [mlfq_pkg::LevelW-1:0]  lv;
    logic [mlfq_pkg::BurstW-1:0]  quantum;
    logic [mlfq_pkg::BurstW-1:0]  rem;
    logic                         done;
    logic [mlfq_pkg::BurstW-1:0]  grant;
    logic [mlfq_pkg::TimeW-1:0]   clock_after;
    logic                         cswitch;
    logic                         accept;
    mlfq_pkg::result_t            res_next;

    assign adm_idx  = IdxW'(cmd.slot);
    assign in_range = (32'(cmd.slot) < SLOTS);
    assign lv       = level_reg[best_reg];
    assign quantum  = mlfq_pkg::BurstW'(1) << lv;
    assign rem      = remain_reg[best_reg];
    assign done     = (rem <= quantum);
    assign grant    = done ? rem : quantum;
    assign clock_after = clock_reg + 32'(grant);
    assign cswitch  = (5'(best_reg) != last_reg);

    assign cmd_ready = (state_reg == S_EXEC) && (!out_valid_reg || res_ready);
    assign accept    = cmd_ready && cmd_valid;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Build the result beat for the command at the head of the queue
    always_comb
    begin
        res_next              = '0;
        res_next.clock_now    = clock_reg;
        res_next.switch_total = switch_reg;
        if (cmd.opcode == mlfq_pkg::OP_ADMIT)
        begin
            if (!in_range || ready_reg[adm_idx])
            begin
                res_next.status = mlfq_pkg::ST_BUSY;
            end
            else if (cmd.burst == '0)
            begin
                res_next.status = mlfq_pkg::ST_ZERO;
            end
            else if (ready_reg == '0 && cmd.arrival_time > clock_reg)
            begin
                res_next.clock_now = cmd.arrival_time;
            end
        end
        else if (!found_reg)
        begin
            res_next.status = mlfq_pkg::ST_NOREADY;
        end
        else
        begin
            res_next.chosen_slot    = mlfq_pkg::SlotW'(best_reg);
            res_next.chosen_level   = lv;
            res_next.run_length     = grant[mlfq_pkg::RunW-1:0];
            res_next.finished       = done;
            res_next.context_switch = cswitch;
            res_next.clock_now      = clock_after;
            res_next.switch_total   = switch_reg + 32'(cswitch);
            res_next.turnaround     = done ? clock_after - arrive_reg[best_reg] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SELECT)
        begin
            found_reg <= found;
            best_reg  <= best;
        end
        if (accept)
        begin
            out_reg <= res_next;
            if (cmd.opcode == mlfq_pkg::OP_ADMIT)
            begin
                if (in_range && !ready_reg[adm_idx] && cmd.burst != '0)
                begin
                    level_reg[adm_idx]  <= '0;
                    remain_reg[adm_idx] <= cmd.burst;
                    arrive_reg[adm_idx] <= cmd.arrival_time;
                end
            end
            else if (found_reg)
            begin
                remain_reg[best_reg] <= done ? '0 : rem - quantum;
                if (!done && (32'(lv) + 1 < LEVELS))
                begin
                    level_reg[best_reg] <= lv + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SELECT;
            ready_reg     <= '0;
            clock_reg     <= '0;
            last_reg      <= 5'h1f;
            switch_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept || (out_valid_reg && !res_ready);
            unique case (state_reg)
                S_SELECT:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SELECT;
                        if (cmd.opcode == mlfq_pkg::OP_ADMIT)
                        begin
                            if (in_range && !ready_reg[adm_idx] && cmd.burst != '0)
                            begin
                                ready_reg[adm_idx] <= 1'b1;
                                if (ready_reg == '0 && cmd.arrival_time > clock_reg)
                                begin
                                    clock_reg <= cmd.arrival_time;
                                end
                            end
                        end
                        else if (found_reg)
                        begin
                            clock_reg  <= clock_after;
                            last_reg   <= 5'(best_reg);
                            switch_reg <= switch_reg + 32'(cswitch);
                            if (done)
                            begin
                                ready_reg[best_reg] <= 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_SELECT;
                end
            endcase
        end
    end

endmodule

// ----- bench/multilevel_feedback_scheduler_tb.sv -----
// Self-checking bench for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler_tb;

    localparam int NSLOT = 16;
    localparam int NLEVEL = 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  chosen_slot;
        logic [2:0]  chosen_level;
        logic [7:0]  run_length;
        logic        finished;
        logic        context_switch;
        logic [31:0] clock_now;
        logic [31:0] turnaround;
        logic [31:0] switch_total;
    } sched_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;   // opcode, slot, arrival_time, burst, pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;   // status, chosen_slot, chosen_level, run_length,
                                  // finished, context_switch, clock_now,
                                  // turnaround, switch_total, pad

    // Shadow of the scheduler state
    logic        pr_ready [NSLOT];
    logic [2:0]  pr_level [NSLOT];
    logic [15:0] pr_remain [NSLOT];
    logic [31:0] pr_arrival [NSLOT];
    logic [31:0] pr_clock;
    logic [4:0]  pr_last;
    logic [31:0] pr_switches;

    sched_result_t pending_results[$];
    int  error_count;
    bit  hold_off;   // long receiver stall requested by the pressure test

    multilevel_feedback_scheduler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int ready_count();
        int n;
        n = 0;
        for (int s = 0; s < NSLOT; s++)
            if (pr_ready[s])
                n++;
        return n;
    endfunction

    // Advance the shadow state by one item and return the expected beat
    function automatic sched_result_t schedule_step(logic op, logic [3:0] slot,
                                                    logic [31:0] arr, logic [15:0] burst);
        sched_result_t r;
        int best;
        int best_lvl;
        logic [15:0] quantum;
        r = '0;
        if (op == mlfq_pkg::OP_ADMIT) begin
            if (pr_ready[slot])
                r.status = mlfq_pkg::ST_BUSY;
            else if (burst == 0)
                r.status = mlfq_pkg::ST_ZERO;
            else begin
                if (ready_count() == 0 && arr > pr_clock)
                    pr_clock = arr;
                pr_ready[slot]   = 1'b1;
                pr_level[slot]   = '0;
                pr_remain[slot]  = burst;
                pr_arrival[slot] = arr;
                r.status = mlfq_pkg::ST_OK;
            end
        end else begin
            best = NSLOT;
            best_lvl = NLEVEL;
            for (int s = 0; s < NSLOT; s++)
                if (pr_ready[s] && int'(pr_level[s]) < best_lvl) begin
                    best = s;
                    best_lvl = pr_level[s];
                end
            if (best == NSLOT)
                r.status = mlfq_pkg::ST_NOREADY;
            else begin
                quantum = 16'd1 << best_lvl;
                if (5'(best) != pr_last) begin
                    r.context_switch = 1'b1;
                    pr_switches++;
                end
                pr_last = 5'(best);
                r.chosen_slot = 4'(best);
                r.chosen_level = 3'(best_lvl);
                if (pr_remain[best] <= quantum) begin
                    r.run_length = 8'(pr_remain[best]);
                    pr_clock += pr_remain[best];
                    r.finished = 1'b1;
                    r.turnaround = pr_clock - pr_arrival[best];
                    pr_ready[best] = 1'b0;
                    pr_remain[best] = '0;
                end else begin
                    r.run_length = 8'(quantum);
                    pr_clock += quantum;
                    pr_remain[best] -= quantum;
                    if (best_lvl + 1 < NLEVEL)
                        pr_level[best] = 3'(best_lvl + 1);
                end
            end
        end
        r.clock_now = pr_clock;
        r.switch_total = pr_switches;
        return r;
    endfunction

    // Offer one beat after a random gap, predict on acceptance
    task automatic send_item(logic op, logic [3:0] slot, logic [31:0] arr,
                             logic [15:0] burst, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, burst, arr, slot, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(schedule_step(op, slot, arr, burst));
    endtask

    // Receiver: random stalls, plus the long hold-off when requested
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        sched_result_t exp_r;
        sched_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = m_axis_tdata[1:0];
            got.chosen_slot    = m_axis_tdata[5:2];
            got.chosen_level   = m_axis_tdata[8:6];
            got.run_length     = m_axis_tdata[16:9];
            got.finished       = m_axis_tdata[17];
            got.context_switch = m_axis_tdata[18];
            got.clock_now      = m_axis_tdata[50:19];
            got.turnaround     = m_axis_tdata[82:51];
            got.switch_total   = m_axis_tdata[114:83];
            if (pending_results.size() == 0) begin
                $display("%t: unexpected beat, actual %p", $time, got);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    $display("%t: expected %p, actual %p", $time, exp_r, got);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [3:0] free_slot();
        for (int s = 0; s < NSLOT; s++)
            if (!pr_ready[s])
                return 4'(s);
        return 4'd0;
    endfunction

    // Directed: extremes, errors, idle clock jump, last level, empty dispatch
    task automatic test_directed();
        send_item(mlfq_pkg::OP_DISPATCH, 4'd0, '0, '0);                 // nothing ready
        send_item(mlfq_pkg::OP_ADMIT, 4'd0, 32'd100, 16'd0);            // zero burst
        send_item(mlfq_pkg::OP_ADMIT, 4'd0, 32'd100, 16'd300);          // clock jumps to 100
        send_item(mlfq_pkg::OP_ADMIT, 4'd0, 32'd5, 16'd7);              // busy
        send_item(mlfq_pkg::OP_ADMIT, 4'd0, 32'd5, 16'd0);              // busy beats zero check
        send_item(mlfq_pkg::OP_ADMIT, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);  // no jump: slot 0 ready
        send_item(mlfq_pkg::OP_ADMIT, 4'd7, 32'd0, 16'd1);
        for (int i = 0; i < 14; i++)
            send_item(mlfq_pkg::OP_DISPATCH, 4'(i), '0, '0);
        send_item(mlfq_pkg::OP_ADMIT, 4'd3, 32'hFFFF_FFF0, 16'd2);
        send_item(mlfq_pkg::OP_DISPATCH, 4'hF, 32'hFFFF_FFFF, 16'hFFFF);
    endtask

    // Dispatch the last-level process repeatedly, then re-admit each ready slot
    task automatic test_last_level();
        for (int i = 0; i < 40; i++)
            send_item(mlfq_pkg::OP_DISPATCH, '0, '0, '0);
        for (int s = 0; s < NSLOT; s++)
            if (pr_ready[s])
                send_item(mlfq_pkg::OP_ADMIT, 4'(s), $urandom, 16'($urandom));
    endtask

    // Random mix: admits (to a free slot or to any slot) and dispatches
    task automatic test_random(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4 && ready_count() < NSLOT)
                send_item(mlfq_pkg::OP_ADMIT,
                          free_slot() ^ 4'($urandom_range(0, 1) * $urandom),
                          ($urandom_range(0, 3) == 0) ? $urandom
                                                      : pr_clock + $urandom_range(0, 50),
                          ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 300)));
            else if (pick < 5)
                send_item(mlfq_pkg::OP_ADMIT, 4'($urandom), $urandom,
                          16'($urandom_range(0, 2)));
            else
                send_item(mlfq_pkg::OP_DISPATCH, 4'($urandom), $urandom, 16'($urandom));
        end
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(($urandom_range(0, 1) == 0) ? mlfq_pkg::OP_ADMIT : mlfq_pkg::OP_DISPATCH,
                      4'($urandom), pr_clock + 3, 16'($urandom_range(1, 20)), 1);
    endtask

    initial
    begin
        error_count = 0;
        hold_off = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        for (int s = 0; s < NSLOT; s++) begin
            pr_ready[s] = 1'b0;
            pr_level[s] = '0;
            pr_remain[s] = '0;
            pr_arrival[s] = '0;
        end
        pr_clock = '0;
        pr_last = 5'h1F;
        pr_switches = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_last_level();
        test_backpressure();
        test_random(460);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mlfq_pkg.sv
hdl/mlfq_front.sv
hdl/mlfq_back.sv
hdl/multilevel_feedback_scheduler.sv
bench/multilevel_feedback_scheduler_tb.sv
